// ===== sv/bm3x3_pkg.sv =====
// Shared types, register codes and the 3x3 window result function.
package bm3x3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 3;

  localparam logic [7:0] FG_LEVEL = 8'd255;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OP_MODE      = 3'd0,
    REG_HIT_MASK     = 3'd1,
    REG_MISS_MASK    = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } bm3x3_reg_t;

  typedef enum logic [1:0] {
    MODE_ERODE    = 2'd0,
    MODE_DILATE   = 2'd1,
    MODE_HIT_MISS = 2'd2
  } bm3x3_mode_t;

  typedef struct packed {
    bm3x3_mode_t op_mode;
    logic [8:0]  hit_mask;
    logic [8:0]  miss_mask;
  } bm3x3_cfg_t;

  // Window for one result plus where its centre sits in the frame
  typedef struct packed {
    logic [8:0] win;
    logic       ox_first;
    logic       ox_last;
    logic       oy_first;
    logic       oy_last;
  } bm3x3_tap_t;

  function automatic logic morph_result(bm3x3_cfg_t cfg, bm3x3_tap_t tap);
    logic       ring;
    logic       hit_ok;
    logic       miss_ok;
    logic [8:0] refl;
    logic [8:0] inside_frame;
    logic [8:0] inv;
    logic       res;
    ring = tap.ox_first | tap.ox_last | tap.oy_first | tap.oy_last;
    inv  = ~tap.win;
    for (int k = 0; k < 9; k++) begin
      refl[8-k] = cfg.hit_mask[k];
      inside_frame[k] = !((k % 3 == 0) && tap.ox_first) && !((k % 3 == 2) && tap.ox_last) &&
                        !((k / 3 == 0) && tap.oy_first) && !((k / 3 == 2) && tap.oy_last);
    end
    hit_ok  = !ring && ((tap.win & cfg.hit_mask) == cfg.hit_mask);
    miss_ok = !ring && ((inv & cfg.miss_mask) == cfg.miss_mask);
    case (cfg.op_mode)
      MODE_ERODE:    res = hit_ok;
      MODE_DILATE:   res = |(tap.win & refl & inside_frame);
      MODE_HIT_MISS: res = hit_ok & miss_ok;
      default:       res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/bm3x3_line_store.sv =====
// Two one-bit line stores sharing one address: bit 1 middle row, bit 0 upper row.
module bm3x3_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/bm3x3_front.sv =====
// Position counters, 3x3 window, line store access and the window stage register.
module bm3x3_front import bm3x3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic          accept,
  input  logic          kind,
  input  logic [7:0]    pixel,
  input  logic [WW-1:0] eff_w,
  input  logic [HW-1:0] eff_h,
  input  logic          s1_free,
  output logic          s1_valid,
  output bm3x3_tap_t    tap
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [CW-1:0] col, col_next, rd_addr;
  logic [RW-1:0] row, row_next, h_ext;
  logic [8:0]    window, window_next, shifted, eval;
  logic [1:0]    rd_word;
  logic          act, draining, fg, emit, last_col, eof;
  logic          ox_first, ox_last, oy_first, oy_last;

  always_comb begin
    h_ext    = RW'(eff_h);
    draining = row >= h_ext;
    act      = accept && (draining || !kind);
    fg       = !draining && (pixel == FG_LEVEL);

    shifted     = (window >> 1) & 9'h0DB;
    window_next = shifted | {fg, 2'b00, rd_word[1], 2'b00, rd_word[0], 2'b00};
    eval        = (col == '0) ? shifted : window_next;

    emit     = (row >= RW'(2)) || (row == RW'(1) && col != '0);
    ox_last  = (col == '0);
    ox_first = (col == CW'(1));
    oy_first = ox_last ? (row == RW'(2)) : (row == RW'(1));
    oy_last  = ox_last ? (row == h_ext + RW'(1)) : (row == h_ext);
    eof      = ox_last && oy_last;

    last_col = (WW'(col) == eff_w - WW'(1));
    if (eof) begin
      col_next = '0;
      row_next = '0;
    end else if (last_col) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end

    // prefetch the store entry the next beat will need
    if (rst || restart) begin
      rd_addr = '0;
    end else if (act) begin
      rd_addr = col_next;
    end else begin
      rd_addr = col;
    end
  end

  bm3x3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_store (
    .clk     (clk),
    .wr_en   (act),
    .wr_addr (col),
    .wr_data ({fg, rd_word[1]}),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col    <= '0;
      row    <= '0;
      window <= '0;
    end else if (act) begin
      col    <= col_next;
      row    <= row_next;
      window <= eof ? 9'd0 : window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= act && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (act && emit) begin
      tap.win      <= eval;
      tap.ox_first <= ox_first;
      tap.ox_last  <= ox_last;
      tap.oy_first <= oy_first;
      tap.oy_last  <= oy_last;
    end
  end

endmodule

// ===== sv/bm3x3_kernel.sv =====
// Morphology operator on the registered window and the output register.
module bm3x3_kernel import bm3x3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bm3x3_tap_t tap,
  input  bm3x3_cfg_t cfg,
  input  logic       out_stall,
  output logic       out_valid,
  output logic       out_fg,
  output logic       end_of_frame
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_fg       <= morph_result(cfg, tap);
      end_of_frame <= tap.ox_last && tap.oy_last;
    end
  end

endmodule

// ===== sv/binary_morphology_3x3.sv =====
// Top level of the streaming 3x3 binary morphology block.
//
// Pixels arrive in raster order, one beat each, and a pixel is foreground
// only when it equals 255. The block returns one binary result per pixel, one
// row plus one pixel behind the input: erosion by hit_mask, dilation by the
// reflected hit_mask, or hit-or-miss (erosion by hit_mask AND erosion of the
// complement by miss_mask); mode code 3 gives 0. Erosion and hit-or-miss give
// 0 on the outer one-pixel ring. After the last pixel of a frame the host
// sends clamped width+1 further beats (flush ticks, or pixels, which are then
// ignored) to drain the tail; the result flagged end_of_frame closes the
// frame. A flush tick sent mid-frame is consumed with no effect. Throughput
// is one beat per clock while the output is not stalled; each result passes
// through the window stage register, loaded when the beat releasing it is
// accepted, and then through the output register.
// The two line stores share one 1-bit-wide-per-row RAM whose next read is
// prefetched, so each beat costs one RAM read and one RAM write. Geometry is
// clamped to 3..MAX_WIDTH by 3..MAX_HEIGHT; writing frame_width or
// frame_height restarts the frame. Registers may only be written while idle.
module binary_morphology_3x3 import bm3x3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input beats
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   kind,
  input  logic [7:0]             pixel,
  // result beats
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_fg,
  output logic                   end_of_frame
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  bm3x3_cfg_t  cfg;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic        restart;
  logic        s1_valid, s1_free, out_load, in_accept;
  bm3x3_tap_t  tap;

  // Configuration registers; geometry writes restart the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode   <= MODE_ERODE;
      cfg.hit_mask  <= 9'h1FF;
      cfg.miss_mask <= 9'h000;
      frame_width   <= 11'd640;
      frame_height  <= 13'd480;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OP_MODE:      cfg.op_mode   <= bm3x3_mode_t'(cfg_data[1:0]);
        REG_HIT_MASK:     cfg.hit_mask  <= cfg_data[8:0];
        REG_MISS_MASK:    cfg.miss_mask <= cfg_data[8:0];
        REG_FRAME_WIDTH:  frame_width   <= cfg_data[10:0];
        REG_FRAME_HEIGHT: frame_height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_write &&
                   (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // Clamp geometry into the supported range
  always_comb begin
    if (frame_width < 11'd3) begin
      eff_w = WW'(3);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    if (frame_height < 13'd3) begin
      eff_h = HW'(3);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height);
    end
  end

  // Two-register pipeline flow control
  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign s1_free   = !s1_valid || out_load;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;

  bm3x3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .accept   (in_accept),
    .kind     (kind),
    .pixel    (pixel),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .s1_free  (s1_free),
    .s1_valid (s1_valid),
    .tap      (tap)
  );

  bm3x3_kernel u_kernel (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .tap          (tap),
    .cfg          (cfg),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_fg       (out_fg),
    .end_of_frame (end_of_frame)
  );

`ifndef NO_ASSERTIONS
  // a result only appears after a window was waiting in stage one
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(s1_valid))
    else $error("result valid without a pending window");

  // a full, blocked pipeline must hold the input off
  assert property (@(posedge clk) disable iff (rst)
                   (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while pipeline blocked");

  // once the last result is taken with nothing behind it, no result is repeated
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated");
`endif

endmodule
